// ===== sv/tali_pkg.sv =====
// ----------------------------------------------------------------------------
// tali_pkg
// Shared widths, constants and types of the three-axis line step interpolator.
// ----------------------------------------------------------------------------
package tali_pkg;

	localparam int POS_WIDTH  = 20;
	localparam int FRAC_BITS  = 8;
	localparam int CNT_WIDTH  = 24;
	localparam int SPM_WIDTH  = 12;
	localparam int DIFF_WIDTH = POS_WIDTH + 1;
	localparam int PROD_WIDTH = DIFF_WIDTH + SPM_WIDTH;

	localparam logic [SPM_WIDTH-1:0] SPM_RESET = SPM_WIDTH'(100);
	localparam logic [CNT_WIDTH-1:0] CNT_MAX   = {CNT_WIDTH{1'b1}};

	typedef enum logic {
		OP_MOVE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// per-transaction strobes from the controller to each axis
	typedef struct packed {
		logic load;
		logic tick;
	} axis_ctl_t;

endpackage

// ===== sv/tali_axis.sv =====
// ----------------------------------------------------------------------------
// tali_axis
// One axis: step count of a new move, direction, position and DDA accumulator.
// ----------------------------------------------------------------------------
module tali_axis (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tali_pkg::axis_ctl_t            ctl,
	input  logic [tali_pkg::POS_WIDTH-1:0] target,
	input  logic [tali_pkg::SPM_WIDTH-1:0] scale,
	input  logic [tali_pkg::CNT_WIDTH-1:0] major_count,
	output logic [tali_pkg::CNT_WIDTH-1:0] count_new,
	output logic                           dir_next,
	output logic                           step_hit
);
	import tali_pkg::*;

	logic [POS_WIDTH-1:0]  position_q;
	logic [CNT_WIDTH-1:0]  count_q;
	logic [CNT_WIDTH-1:0]  accum_q;
	logic                  dir_q;

	logic signed [DIFF_WIDTH-1:0] diff;
	logic [DIFF_WIDTH-1:0]        mag;
	logic [PROD_WIDTH-1:0]        prod;
	logic [PROD_WIDTH-1:0]        scaled;
	logic                         neg;
	logic                         dir_new;
	logic [CNT_WIDTH:0]           sum;
	logic [CNT_WIDTH-1:0]         accum_next;

	always_comb begin
		diff = $signed({target[POS_WIDTH-1], target})
			- $signed({position_q[POS_WIDTH-1], position_q});
		neg  = diff[DIFF_WIDTH-1];
		mag  = neg ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
		prod = PROD_WIDTH'(mag) * PROD_WIDTH'(scale);
		scaled = prod >> FRAC_BITS;
		if (scaled > PROD_WIDTH'(CNT_MAX)) begin
			count_new = CNT_MAX;
		end else begin
			count_new = scaled[CNT_WIDTH-1:0];
		end
		// a delta truncated to zero counts as positive
		dir_new  = !(neg && (count_new != '0));
		dir_next = ctl.load ? dir_new : dir_q;

		sum      = {1'b0, accum_q} + {1'b0, count_q};
		step_hit = sum >= {1'b0, major_count};
		accum_next = step_hit ? CNT_WIDTH'(sum - {1'b0, major_count})
			: sum[CNT_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			count_q    <= '0;
			accum_q    <= '0;
			dir_q      <= 1'b1;
		end else if (ctl.load) begin
			position_q <= target;
			count_q    <= count_new;
			accum_q    <= '0;
			dir_q      <= dir_new;
		end else if (ctl.tick) begin
			accum_q <= accum_next;
		end
	end

endmodule

// ===== sv/three_axis_line_step_interpolator.sv =====
// ----------------------------------------------------------------------------
// three_axis_line_step_interpolator
// Three-axis linear move interpolator driving step and direction outputs.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries op, target_x, target_y and
//   target_z. op = move loads a new target, op = tick advances the move by one
//   step period. Every input transaction yields exactly one result on the
//   output channel (out_valid/out_ready): step pulses, directions, busy_res,
//   move_done and rejected. A move sent while busy is rejected.
//   The steps-per-mm scale is written as cfg_data over the cfg_valid/cfg_ready
//   channel, which is always ready; write it only while no move or tick is in
//   flight.
// Pipeline and throughput:
//   an accepted transaction is held in the input register until the output
//   register is free or being taken, then processed, and its result is
//   registered on the output channel. With out_ready high, one transaction
//   per cycle is sustained; the path per cycle is one 21 x 12 multiply per
//   axis on a move, or one add, compare and subtract per axis on a tick.
// Reset and stalls:
//   arst_n clears all positions, counts and accumulators, sets the
//   directions positive and the scale to 100 steps per mm. When out_ready is
//   low the result holds, the input register fills and in_ready then drops.
// ----------------------------------------------------------------------------
module three_axis_line_step_interpolator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tali_pkg::SPM_WIDTH-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [tali_pkg::POS_WIDTH-1:0] target_x,
	input  logic [tali_pkg::POS_WIDTH-1:0] target_y,
	input  logic [tali_pkg::POS_WIDTH-1:0] target_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           step_x,
	output logic                           step_y,
	output logic                           step_z,
	output logic                           dir_x,
	output logic                           dir_y,
	output logic                           dir_z,
	output logic                           busy_res,
	output logic                           move_done,
	output logic                           rejected
);
	import tali_pkg::*;

	logic [SPM_WIDTH-1:0] spm_q;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [POS_WIDTH-1:0] tgt_x_s1;
	logic [POS_WIDTH-1:0] tgt_y_s1;
	logic [POS_WIDTH-1:0] tgt_z_s1;

	logic [CNT_WIDTH-1:0] major_q;
	logic [CNT_WIDTH-1:0] ticks_left_q;
	logic                 moving_q;

	logic                 advance;
	axis_ctl_t            ctl;
	logic [CNT_WIDTH-1:0] cnt_x, cnt_y, cnt_z;
	logic [CNT_WIDTH-1:0] max_xy, max_xyz;
	logic                 dnx, dny, dnz;
	logic                 hit_x, hit_y, hit_z;
	logic                 moving_next;
	logic                 done_next;
	logic                 rej_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spm_q <= SPM_RESET;
		end else if (cfg_valid) begin
			spm_q <= cfg_data;
		end
	end

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op_t'(op);
			tgt_x_s1 <= target_x;
			tgt_y_s1 <= target_y;
			tgt_z_s1 <= target_z;
		end
	end

	always_comb begin
		ctl.load = advance && (op_s1 == OP_MOVE) && !moving_q;
		ctl.tick = advance && (op_s1 == OP_TICK) && moving_q;
	end

	tali_axis u_axis_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .target(tgt_x_s1),
		.scale(spm_q), .major_count(major_q),
		.count_new(cnt_x), .dir_next(dnx), .step_hit(hit_x)
	);

	tali_axis u_axis_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .target(tgt_y_s1),
		.scale(spm_q), .major_count(major_q),
		.count_new(cnt_y), .dir_next(dny), .step_hit(hit_y)
	);

	tali_axis u_axis_z (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .target(tgt_z_s1),
		.scale(spm_q), .major_count(major_q),
		.count_new(cnt_z), .dir_next(dnz), .step_hit(hit_z)
	);

	always_comb begin
		max_xy  = (cnt_y > cnt_x) ? cnt_y : cnt_x;
		max_xyz = (cnt_z > max_xy) ? cnt_z : max_xy;
		rej_next = (op_s1 == OP_MOVE) && moving_q;
		priority if (ctl.load) begin
			moving_next = max_xyz != '0;
			done_next   = max_xyz == '0;
		end else if (ctl.tick) begin
			// last tick of the move when one tick remains
			moving_next = ticks_left_q != CNT_WIDTH'(1);
			done_next   = ticks_left_q == CNT_WIDTH'(1);
		end else begin
			moving_next = moving_q;
			done_next   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q      <= '0;
			ticks_left_q <= '0;
			moving_q     <= 1'b0;
		end else if (ctl.load) begin
			major_q      <= max_xyz;
			ticks_left_q <= max_xyz;
			moving_q     <= moving_next;
		end else if (ctl.tick) begin
			ticks_left_q <= ticks_left_q - CNT_WIDTH'(1);
			moving_q     <= moving_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			step_x    <= ctl.tick && hit_x;
			step_y    <= ctl.tick && hit_y;
			step_z    <= ctl.tick && hit_z;
			dir_x     <= dnx;
			dir_y     <= dny;
			dir_z     <= dnz;
			busy_res  <= moving_next;
			move_done <= done_next;
			rejected  <= rej_next;
		end
	end

`ifndef SYNTHESIS
	// a move is in progress exactly while ticks remain
	assert property (@(posedge clk) disable iff (!arst_n)
		moving_q == (ticks_left_q != '0))
	else $error("moving flag disagrees with remaining tick count");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(move_done && busy_res))
	else $error("result reports done and busy at once");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !step_x && !step_y && !step_z && !move_done)
	else $error("rejected move produced steps or ended the move");

	// a result that is not taken must not be overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !advance)
	else $error("pending result overwritten");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-axis line step interpolator.
// A short table of directed transactions runs first. Random phases at several
// step rates follow, each one started from a finished move and a drained block.
// Every result is checked against a behavioral copy of the axis arithmetic or,
// for typed table rows, against the table. Both channels idle at random, and
// one long output hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tali_pkg::*;

	localparam int POS_HI = (1 << (POS_WIDTH - 1)) - 1;
	localparam int POS_LO = -(1 << (POS_WIDTH - 1));
	localparam logic [POS_WIDTH-1:0] P_MAX = POS_WIDTH'(POS_HI);
	localparam logic [POS_WIDTH-1:0] P_MIN = POS_WIDTH'(POS_LO);
	localparam int PHASE_ITEMS = 265;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic step_x;
		logic step_y;
		logic step_z;
		logic dir_x;
		logic dir_y;
		logic dir_z;
		logic busy;
		logic done;
		logic rej;
	} motion_res_t;

	typedef struct packed {
		op_t                  code;
		logic [POS_WIDTH-1:0] tx;
		logic [POS_WIDTH-1:0] ty;
		logic [POS_WIDTH-1:0] tz;
		logic                 typed;
		motion_res_t          want;
	} plan_row_t;

	localparam int PLAN_LEN = 24;
	localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b1, 9'b000_111_000},
		'{OP_TICK, P_MAX, P_MIN, P_MAX, 1'b1, 9'b000_111_000},
		'{OP_MOVE, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b1, 9'b000_111_010},
		'{OP_MOVE, POS_WIDTH'(-1), POS_WIDTH'(-1), POS_WIDTH'(-1), 1'b1, 9'b000_111_010},
		'{OP_MOVE, POS_WIDTH'(4), POS_WIDTH'(-7), POS_WIDTH'(1), 1'b0, 9'b0},
		'{OP_MOVE, P_MAX, P_MIN, P_MAX, 1'b0, 9'b0},
		'{OP_MOVE, P_MIN, P_MAX, P_MIN, 1'b0, 9'b0},
		'{OP_TICK, P_MIN, P_MIN, P_MIN, 1'b0, 9'b0},
		'{OP_TICK, P_MAX, P_MAX, P_MAX, 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_MOVE, POS_WIDTH'(14), POS_WIDTH'(-7), POS_WIDTH'(1), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_MOVE, POS_WIDTH'(4), POS_WIDTH'(-17), POS_WIDTH'(-9), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		// same target again: zero-length move puts all directions back to positive
		'{OP_MOVE, POS_WIDTH'(4), POS_WIDTH'(-17), POS_WIDTH'(-9), 1'b1, 9'b000_111_010},
		'{OP_MOVE, POS_WIDTH'(-5), POS_WIDTH'(-16), POS_WIDTH'(-9), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_MOVE, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0},
		'{OP_TICK, POS_WIDTH'(0), POS_WIDTH'(0), POS_WIDTH'(0), 1'b0, 9'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [SPM_WIDTH-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 op;
	logic [POS_WIDTH-1:0] target_x;
	logic [POS_WIDTH-1:0] target_y;
	logic [POS_WIDTH-1:0] target_z;
	logic                 out_valid;
	logic                 out_ready;
	logic                 step_x;
	logic                 step_y;
	logic                 step_z;
	logic                 dir_x;
	logic                 dir_y;
	logic                 dir_z;
	logic                 busy_res;
	logic                 move_done;
	logic                 rejected;

	// behavioral copy of the axis state
	logic [SPM_WIDTH-1:0] rate_m;
	logic [POS_WIDTH-1:0] pos_m [0:2];
	logic [CNT_WIDTH-1:0] steps_m [0:2];
	logic [CNT_WIDTH-1:0] acc_m [0:2];
	logic [CNT_WIDTH-1:0] major_m;
	logic [CNT_WIDTH-1:0] ticks_m;
	logic [2:0]           dir_m;
	logic                 moving_m;

	motion_res_t pending_res [$];
	string fld_name [0:8] = '{"step_x", "step_y", "step_z", "dir_x", "dir_y", "dir_z",
		"busy_res", "move_done", "rejected"};

	int errors = 0;
	int nres = 0;
	int useful = 0;
	int nmoves = 0;
	int nreject = 0;
	int nticks = 0;
	int nidle = 0;
	int nsteps = 0;
	int nrates = 0;
	int rush = 0;
	int stall_asked = 0;
	bit no_idle = 1'b0;

	three_axis_line_step_interpolator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.target_x(target_x),
		.target_y(target_y),
		.target_z(target_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.step_x(step_x),
		.step_y(step_y),
		.step_z(step_z),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.busy_res(busy_res),
		.move_done(move_done),
		.rejected(rejected)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("run timed out with %0d results outstanding", pending_res.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = int'($urandom_range(0, 99));
		if (r < 70)
			return 0;
		if (r < 95)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(12, 40));
	endfunction

	// one transaction: a move loads the axes unless busy, a tick advances a move in progress
	task automatic advance_axes(input op_t code, input logic [POS_WIDTH-1:0] tx,
		input logic [POS_WIDTH-1:0] ty, input logic [POS_WIDTH-1:0] tz,
		output motion_res_t r);
		logic [POS_WIDTH-1:0] tv [0:2];
		logic [2:0]           pulse;
		logic                 done;
		logic                 rej;
		logic [CNT_WIDTH:0]   sum;
		logic [CNT_WIDTH-1:0] top;
		longint               diff;
		longint               mag;
		int                   i;
		tv[0] = tx;
		tv[1] = ty;
		tv[2] = tz;
		pulse = 3'b000;
		done = 1'b0;
		rej = 1'b0;
		if (code == OP_MOVE) begin
			if (moving_m) begin
				rej = 1'b1;
			end else begin
				top = '0;
				for (i = 0; i < 3; i++) begin
					diff = longint'($signed(tv[i])) - longint'($signed(pos_m[i]));
					mag = (diff < 0) ? -diff : diff;
					mag = (mag * longint'(rate_m)) >> FRAC_BITS;
					if (mag > longint'(CNT_MAX))
						mag = longint'(CNT_MAX);
					steps_m[i] = mag[CNT_WIDTH-1:0];
					acc_m[i] = '0;
					// a delta that truncates to no steps counts as positive
					dir_m[i] = !(diff < 0 && mag != 0);
					if (steps_m[i] > top)
						top = steps_m[i];
					pos_m[i] = tv[i];
				end
				major_m = top;
				ticks_m = top;
				moving_m = (top != '0);
				done = (top == '0);
			end
		end else if (moving_m) begin
			for (i = 0; i < 3; i++) begin
				sum = {1'b0, acc_m[i]} + {1'b0, steps_m[i]};
				if (sum >= {1'b0, major_m}) begin
					sum = sum - {1'b0, major_m};
					pulse[i] = 1'b1;
				end
				acc_m[i] = sum[CNT_WIDTH-1:0];
			end
			ticks_m = ticks_m - 1'b1;
			if (ticks_m == '0) begin
				moving_m = 1'b0;
				done = 1'b1;
			end
		end
		r = {pulse[0], pulse[1], pulse[2], dir_m[0], dir_m[1], dir_m[2], moving_m, done, rej};
	endtask

	task automatic offer(input op_t code, input logic [POS_WIDTH-1:0] tx,
		input logic [POS_WIDTH-1:0] ty, input logic [POS_WIDTH-1:0] tz,
		input logic typed, input motion_res_t want);
		motion_res_t r;
		logic        was_moving;
		int          gap;
		gap = idle_len();
		if (rush > 0) begin
			rush--;
			gap = 0;
		end
		if (gap != 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		op = code;
		target_x = tx;
		target_y = ty;
		target_z = tz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		was_moving = moving_m;
		advance_axes(code, tx, ty, tz, r);
		pending_res.push_back(typed ? want : r);
		if (code == OP_MOVE && r.rej) begin
			nreject++;
		end else if (code == OP_TICK && !was_moving) begin
			nidle++;
		end else begin
			useful++;
			if (code == OP_MOVE)
				nmoves++;
			else
				nticks++;
		end
	endtask

	task automatic run_out();
		while (moving_m)
			offer(OP_TICK, POS_WIDTH'($urandom), POS_WIDTH'($urandom), POS_WIDTH'($urandom),
				1'b0, '0);
	endtask

	// block drained: every transaction so far has its result back
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	task automatic load_rate(input logic [SPM_WIDTH-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		rate_m = v;
		nrates++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [POS_WIDTH-1:0] near_target(input logic [POS_WIDTH-1:0] cur,
		input int span);
		int c;
		int d;
		int t;
		c = int'($signed(cur));
		d = int'($urandom_range(0, span));
		if ($urandom_range(0, 1) != 0)
			d = -d;
		if ($urandom_range(0, 4) == 0)
			d = 0;
		t = c + d;
		if (t > POS_HI || t < POS_LO)
			t = c - d;
		return POS_WIDTH'(t);
	endfunction

	task automatic random_item();
		int pick;
		int span;
		pick = int'($urandom_range(0, 99));
		// keep most moves to at most 24 steps per axis whatever the rate
		span = (24 << FRAC_BITS) / int'(rate_m);
		if ($urandom_range(0, 19) == 0)
			span = span * 8;
		if (moving_m) begin
			if (pick < 92)
				offer(OP_TICK, POS_WIDTH'($urandom), POS_WIDTH'($urandom),
					POS_WIDTH'($urandom), 1'b0, '0);
			else
				offer(OP_MOVE, POS_WIDTH'($urandom), POS_WIDTH'($urandom),
					POS_WIDTH'($urandom), 1'b0, '0);
		end else if (pick < 78) begin
			offer(OP_MOVE, near_target(pos_m[0], span), near_target(pos_m[1], span),
				near_target(pos_m[2], span), 1'b0, '0);
		end else if (pick < 86) begin
			offer(OP_MOVE, pos_m[0], pos_m[1], pos_m[2], 1'b0, '0);
		end else begin
			offer(OP_TICK, POS_WIDTH'($urandom), POS_WIDTH'($urandom), POS_WIDTH'($urandom),
				1'b0, '0);
		end
	endtask

	function automatic logic [SPM_WIDTH-1:0] rate_for(input int phase);
		case (phase)
			0: return {SPM_WIDTH{1'b1}};
			1: return SPM_WIDTH'(1);
			3: return SPM_RESET;
			default: return SPM_WIDTH'($urandom_range(2, (1 << SPM_WIDTH) - 2));
		endcase
	endfunction

	// output side: random back-pressure plus one long hold-off on request
	initial begin
		int hold;
		int stall_seen;
		out_ready = 1'b0;
		hold = 0;
		stall_seen = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_asked != stall_seen) begin
				stall_seen = stall_asked;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = 1'b1;
				hold = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		motion_res_t got;
		motion_res_t want;
		int i;
		if (arst_n && out_valid && out_ready) begin
			got = {step_x, step_y, step_z, dir_x, dir_y, dir_z, busy_res, move_done, rejected};
			nsteps += int'(step_x) + int'(step_y) + int'(step_z);
			if (pending_res.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with nothing expected", nres));
			end else begin
				want = pending_res.pop_front();
				for (i = 0; i < 9; i++)
					if (got[8-i] !== want[8-i])
						flag_mismatch($sformatf("result %0d %s got %b want %b", nres,
							fld_name[i], got[8-i], want[8-i]));
			end
			nres++;
		end
	end

	initial begin
		int k;
		int goal;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = SPM_RESET;
		in_valid = 1'b0;
		op = OP_TICK;
		target_x = '0;
		target_y = '0;
		target_z = '0;
		rate_m = SPM_RESET;
		for (k = 0; k < 3; k++) begin
			pos_m[k] = '0;
			steps_m[k] = '0;
			acc_m[k] = '0;
		end
		major_m = '0;
		ticks_m = '0;
		dir_m = 3'b111;
		moving_m = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < PLAN_LEN; k++)
			offer(PLAN[k].code, PLAN[k].tx, PLAN[k].ty, PLAN[k].tz, PLAN[k].typed, PLAN[k].want);

		for (k = 0; k < 5; k++) begin
			run_out();
			settle();
			load_rate(rate_for(k));
			no_idle = (k == 3);
			if (k == 0) begin
				rush = 60;
				stall_asked++;
			end
			goal = useful + PHASE_ITEMS;
			while (useful < goal)
				random_item();
		end

		@(negedge clk);
		in_valid = 1'b0;
		k = 0;
		while (pending_res.size() != 0 && k < 5000) begin
			@(posedge clk);
			k++;
		end
		repeat (8) @(posedge clk);
		if (pending_res.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_res.size()));

		$display("covered %0d moves, %0d rejected moves, %0d ticks in motion, %0d idle ticks",
			nmoves, nreject, nticks, nidle);
		$display("%0d results, %0d step pulses, %0d rate settings, %0d mismatches",
			nres, nsteps, nrates, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
